@@ rtl/fsp_pkg.sv @@
// Shared types and constants for the brace format-spec parser.
// Used by fsp_core, fsp_out_fifo and format_string_field_parser; no dependencies.

package fsp_pkg;

    // Characters the parser looks for
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_LESS   = 8'h3C;
    localparam logic [7:0] CH_MORE   = 8'h3E;
    localparam logic [7:0] CH_CARET  = 8'h5E;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_E      = 8'h65;
    localparam logic [7:0] CH_G      = 8'h67;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;

    localparam int DECIMAL_BASE = 10;

    // Result kinds
    localparam logic [1:0] KIND_LITERAL = 2'd0;
    localparam logic [1:0] KIND_VALID   = 2'd1;
    localparam logic [1:0] KIND_INVALID = 2'd2;

    // Alignment codes
    localparam logic [1:0] ALIGN_NONE   = 2'd0;
    localparam logic [1:0] ALIGN_LEFT   = 2'd1;
    localparam logic [1:0] ALIGN_RIGHT  = 2'd2;
    localparam logic [1:0] ALIGN_CENTER = 2'd3;

    // Notation codes
    localparam logic [2:0] NOTE_NONE     = 3'd0;
    localparam logic [2:0] NOTE_E        = 3'd1;
    localparam logic [2:0] NOTE_G        = 3'd2;
    localparam logic [2:0] NOTE_R_DIGITS = 3'd3;
    localparam logic [2:0] NOTE_R_BARE   = 3'd4;

    // Output queue depth; must hold two results past a full drain cycle
    localparam int RESULT_DEPTH = 4;

    typedef enum logic [3:0] {
        PH_LIT   = 4'd0,
        PH_BRACE = 4'd1,
        PH_ARG   = 4'd2,
        PH_COLON = 4'd3,
        PH_WIDTH = 4'd4,
        PH_PREC  = 4'd5,
        PH_RADIX = 4'd6,
        PH_END   = 4'd7,
        PH_AFTER = 4'd8
    } phase_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic        last;
        logic [15:0] span_start;
        logic [15:0] span_end;
        logic [15:0] arg_index;
        logic [1:0]  align_mode;
        logic [15:0] field_width;
        logic        width_given;
        logic [15:0] precision_value;
        logic        precision_given;
        logic [2:0]  notation;
        logic [15:0] radix_value;
    } result_t;

    // Results produced by one character: zero, one or two words
    typedef struct packed {
        logic [1:0] count;
        result_t    res0;
        result_t    res1;
    } core_out_t;

endpackage

@@ rtl/format_string_field_parser.sv @@
// Brace format-spec parser top level: input register, parser core, result queue.
// Depends on fsp_pkg, fsp_core and fsp_out_fifo.
//
// Usage:
//   s_* carries the format string, one byte per word; a zero byte ends the
//   string and returns position and parser state to their reset values.
//   m_* carries result words: literal spans (m_tuser = 0) and replacement
//   fields (1 valid, 2 invalid). m_tlast marks the final result word caused
//   by one input byte; a byte may cause zero, one or two result words.
// Timing:
//   A byte is registered in the input register on acceptance and parsed
//   once the result queue has room; its words are written into the queue
//   when it is parsed, and m_* is driven from the queue head.
//   One byte per cycle is sustained while each byte yields at most one word
//   and m_tready stays high; a byte with two words occupies the output for
//   each of its words in turn. The 4-word result queue sets the limit: a
//   byte is parsed only while at most two words remain queued after this
//   cycle's pop.
// Reset: asynchronous, active low; input register and queue empty.
// Stall: with m_tready low the queue fills, the input register holds its byte
//   and s_tready drops; no word is lost or repeated.

module format_string_field_parser #(
    parameter int POSITION_BITS = 16,
    parameter int NUMBER_BITS   = 16
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // [7:0] text_char
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [103:0] m_tdata,   // span_start, span_end, arg_index, align_mode,
                                    // field_width, width_given, precision_value,
                                    // precision_given, notation, radix_value, pad
    output logic [1:0]   m_tuser,   // [1:0] kind
    output logic         m_tlast
);

    logic               in_valid_reg, in_valid_next;
    logic [7:0]         char_reg;
    logic               fire;
    logic               room;
    fsp_pkg::core_out_t core_out;
    fsp_pkg::result_t   head;

    assign fire          = in_valid_reg && room;
    assign s_tready      = !in_valid_reg || fire;
    assign in_valid_next = (s_tvalid && s_tready) || (in_valid_reg && !fire);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else
            in_valid_reg <= in_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
            char_reg <= s_tdata;
    end

    fsp_core #(
        .POSITION_BITS (POSITION_BITS),
        .NUMBER_BITS   (NUMBER_BITS)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (fire),
        .text_char (char_reg),
        .core_out  (core_out)
    );

    fsp_out_fifo u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (fire),
        .core_out (core_out),
        .room     (room),
        .m_valid  (m_tvalid),
        .m_ready  (m_tready),
        .head     (head)
    );

    assign m_tuser = head.kind;
    assign m_tlast = head.last;
    assign m_tdata = {1'b0,
                      head.radix_value,
                      head.notation,
                      head.precision_given,
                      head.precision_value,
                      head.width_given,
                      head.field_width,
                      head.align_mode,
                      head.arg_index,
                      head.span_end,
                      head.span_start};

endmodule

@@ rtl/fsp_core.sv @@
// Per-character parser: phase and field accumulators, up to two results per character.
// Depends on fsp_pkg.

module fsp_core #(
    parameter int POSITION_BITS = 16,
    parameter int NUMBER_BITS   = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                fire,
    input  logic [7:0]          text_char,
    output fsp_pkg::core_out_t  core_out
);

    localparam logic [POSITION_BITS-1:0] POS_ONE = POSITION_BITS'(1);
    localparam logic [NUMBER_BITS+3:0]   TEN     = (NUMBER_BITS+4)'(fsp_pkg::DECIMAL_BASE);

    fsp_pkg::phase_t          phase_reg, phase_next;
    logic [POSITION_BITS-1:0] pos_reg, pos_next;
    logic [POSITION_BITS-1:0] span_b_reg, span_b_next;
    logic [NUMBER_BITS-1:0]   arg_reg, arg_next;
    logic                     arg_has_reg, arg_has_next;
    logic [1:0]               align_reg, align_next;
    logic [NUMBER_BITS-1:0]   width_reg, width_next;
    logic                     width_has_reg, width_has_next;
    logic [NUMBER_BITS-1:0]   prec_reg, prec_next;
    logic                     prec_has_reg, prec_has_next;
    logic [2:0]               note_reg, note_next;
    logic [NUMBER_BITS-1:0]   radix_reg, radix_next;

    // value*10 + digit, saturating at all ones
    function automatic logic [NUMBER_BITS-1:0] push_digit(
        input logic [NUMBER_BITS-1:0] v,
        input logic [3:0]             dg
    );
        logic [NUMBER_BITS+3:0] t;
        t = {4'b0000, v} * TEN + {{NUMBER_BITS{1'b0}}, dg};
        if (|t[NUMBER_BITS+3:NUMBER_BITS])
            push_digit = '1;
        else
            push_digit = t[NUMBER_BITS-1:0];
    endfunction

    function automatic fsp_pkg::result_t make_span(
        input logic [POSITION_BITS-1:0] s,
        input logic [POSITION_BITS-1:0] e
    );
        fsp_pkg::result_t r;
        r            = '0;
        r.kind       = fsp_pkg::KIND_LITERAL;
        r.span_start = 16'(s);
        r.span_end   = 16'(e);
        make_span    = r;
    endfunction

    always_comb
    begin
        fsp_pkg::phase_t   ph;
        fsp_pkg::result_t  res [2];
        fsp_pkg::result_t  fld;
        logic [1:0]        n;
        logic              as_lit;
        logic              consumed;
        logic              digit;
        logic [3:0]        dg;
        logic [POSITION_BITS-1:0] p;

        ph             = phase_reg;
        span_b_next    = span_b_reg;
        arg_next       = arg_reg;
        arg_has_next   = arg_has_reg;
        align_next     = align_reg;
        width_next     = width_reg;
        width_has_next = width_has_reg;
        prec_next      = prec_reg;
        prec_has_next  = prec_has_reg;
        note_next      = note_reg;
        radix_next     = radix_reg;
        res[0]         = '0;
        res[1]         = '0;
        fld            = '0;
        n              = 2'd0;
        as_lit         = 1'b0;
        consumed       = 1'b0;
        p              = pos_reg;
        digit          = (text_char >= fsp_pkg::CH_ZERO) && (text_char <= fsp_pkg::CH_NINE);
        dg             = text_char[3:0];

        if (ph == fsp_pkg::PH_BRACE && text_char == fsp_pkg::CH_LBRACE)
        begin
            // doubled brace stays in the literal
            ph = fsp_pkg::PH_LIT;
        end
        else
        begin
            if (ph == fsp_pkg::PH_BRACE)
            begin
                // span ends before the opening brace
                res[n[0]]      = make_span(span_b_next, p - POS_ONE);
                n              = n + 2'd1;
                arg_next       = '0;
                arg_has_next   = 1'b0;
                align_next     = fsp_pkg::ALIGN_NONE;
                width_next     = '0;
                width_has_next = 1'b0;
                prec_next      = '0;
                prec_has_next  = 1'b0;
                note_next      = fsp_pkg::NOTE_NONE;
                radix_next     = '0;
                ph             = fsp_pkg::PH_ARG;
            end

            if (ph >= fsp_pkg::PH_ARG && ph <= fsp_pkg::PH_END)
            begin
                unique case (ph)
                    fsp_pkg::PH_ARG:
                    begin
                        if (digit)
                        begin
                            arg_next     = push_digit(arg_next, dg);
                            arg_has_next = 1'b1;
                            consumed     = 1'b1;
                        end
                        else if (text_char == fsp_pkg::CH_COLON && arg_has_next)
                        begin
                            ph       = fsp_pkg::PH_COLON;
                            consumed = 1'b1;
                        end
                    end
                    fsp_pkg::PH_COLON, fsp_pkg::PH_WIDTH:
                    begin
                        priority if (ph == fsp_pkg::PH_COLON && text_char == fsp_pkg::CH_LESS)
                        begin
                            align_next = fsp_pkg::ALIGN_LEFT;
                            ph         = fsp_pkg::PH_WIDTH;
                            consumed   = 1'b1;
                        end
                        else if (ph == fsp_pkg::PH_COLON && text_char == fsp_pkg::CH_MORE)
                        begin
                            align_next = fsp_pkg::ALIGN_RIGHT;
                            ph         = fsp_pkg::PH_WIDTH;
                            consumed   = 1'b1;
                        end
                        else if (ph == fsp_pkg::PH_COLON && text_char == fsp_pkg::CH_CARET)
                        begin
                            align_next = fsp_pkg::ALIGN_CENTER;
                            ph         = fsp_pkg::PH_WIDTH;
                            consumed   = 1'b1;
                        end
                        else if (digit)
                        begin
                            width_next     = push_digit(width_next, dg);
                            width_has_next = 1'b1;
                            ph             = fsp_pkg::PH_WIDTH;
                            consumed       = 1'b1;
                        end
                        else if (text_char == fsp_pkg::CH_DOT)
                        begin
                            ph       = fsp_pkg::PH_PREC;
                            consumed = 1'b1;
                        end
                        else if (text_char == fsp_pkg::CH_E)
                        begin
                            note_next = fsp_pkg::NOTE_E;
                            ph        = fsp_pkg::PH_END;
                            consumed  = 1'b1;
                        end
                        else if (text_char == fsp_pkg::CH_G)
                        begin
                            note_next = fsp_pkg::NOTE_G;
                            ph        = fsp_pkg::PH_END;
                            consumed  = 1'b1;
                        end
                        else if (text_char == fsp_pkg::CH_R)
                        begin
                            note_next = fsp_pkg::NOTE_R_BARE;
                            ph        = fsp_pkg::PH_RADIX;
                            consumed  = 1'b1;
                        end
                    end
                    fsp_pkg::PH_PREC:
                    begin
                        priority if (digit)
                        begin
                            prec_next     = push_digit(prec_next, dg);
                            prec_has_next = 1'b1;
                            consumed      = 1'b1;
                        end
                        else if (text_char == fsp_pkg::CH_E)
                        begin
                            note_next = fsp_pkg::NOTE_E;
                            ph        = fsp_pkg::PH_END;
                            consumed  = 1'b1;
                        end
                        else if (text_char == fsp_pkg::CH_G)
                        begin
                            note_next = fsp_pkg::NOTE_G;
                            ph        = fsp_pkg::PH_END;
                            consumed  = 1'b1;
                        end
                        else if (text_char == fsp_pkg::CH_R)
                        begin
                            note_next = fsp_pkg::NOTE_R_BARE;
                            ph        = fsp_pkg::PH_RADIX;
                            consumed  = 1'b1;
                        end
                    end
                    fsp_pkg::PH_RADIX:
                    begin
                        if (digit)
                        begin
                            radix_next = push_digit(radix_next, dg);
                            note_next  = fsp_pkg::NOTE_R_DIGITS;
                            consumed   = 1'b1;
                        end
                    end
                    default:
                    begin
                    end
                endcase

                if (!consumed)
                begin
                    fld                 = '0;
                    fld.arg_index       = 16'(arg_next);
                    fld.align_mode      = align_next;
                    fld.field_width     = 16'(width_next);
                    fld.width_given     = width_has_next;
                    fld.precision_value = 16'(prec_next);
                    fld.precision_given = prec_has_next;
                    fld.notation        = note_next;
                    fld.radix_value     = 16'(radix_next);
                    if (text_char == fsp_pkg::CH_RBRACE)
                    begin
                        fld.kind    = arg_has_next ? fsp_pkg::KIND_VALID
                                                   : fsp_pkg::KIND_INVALID;
                        res[n[0]]   = fld;
                        n           = n + 2'd1;
                        ph          = fsp_pkg::PH_AFTER;
                        span_b_next = p + POS_ONE;
                    end
                    else
                    begin
                        // broken field; the character is reread as literal text unless it ends the string
                        fld.kind  = fsp_pkg::KIND_INVALID;
                        res[n[0]] = fld;
                        n         = n + 2'd1;
                        if (text_char != fsp_pkg::CH_NUL)
                        begin
                            ph          = fsp_pkg::PH_LIT;
                            span_b_next = p;
                            as_lit      = 1'b1;
                        end
                    end
                end
            end
            else
            begin
                as_lit = 1'b1;
            end
        end

        if (as_lit)
        begin
            if (text_char == fsp_pkg::CH_NUL)
            begin
                if (ph != fsp_pkg::PH_AFTER)
                begin
                    res[n[0]] = make_span(span_b_next, p);
                    n         = n + 2'd1;
                end
            end
            else if (text_char == fsp_pkg::CH_LBRACE)
                ph = fsp_pkg::PH_BRACE;
            else
                ph = fsp_pkg::PH_LIT;
        end

        if (n == 2'd1)
            res[0].last = 1'b1;
        else if (n == 2'd2)
            res[1].last = 1'b1;

        phase_next = ph;
        pos_next   = p + POS_ONE;

        // end of string: back to reset state
        if (text_char == fsp_pkg::CH_NUL)
        begin
            phase_next     = fsp_pkg::PH_LIT;
            pos_next       = '0;
            span_b_next    = '0;
            arg_next       = '0;
            arg_has_next   = 1'b0;
            align_next     = fsp_pkg::ALIGN_NONE;
            width_next     = '0;
            width_has_next = 1'b0;
            prec_next      = '0;
            prec_has_next  = 1'b0;
            note_next      = fsp_pkg::NOTE_NONE;
            radix_next     = '0;
        end

        core_out.count = n;
        core_out.res0  = res[0];
        core_out.res1  = res[1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= fsp_pkg::PH_LIT;
            pos_reg       <= '0;
            span_b_reg    <= '0;
            arg_reg       <= '0;
            arg_has_reg   <= 1'b0;
            align_reg     <= fsp_pkg::ALIGN_NONE;
            width_reg     <= '0;
            width_has_reg <= 1'b0;
            prec_reg      <= '0;
            prec_has_reg  <= 1'b0;
            note_reg      <= fsp_pkg::NOTE_NONE;
            radix_reg     <= '0;
        end
        else if (fire)
        begin
            phase_reg     <= phase_next;
            pos_reg       <= pos_next;
            span_b_reg    <= span_b_next;
            arg_reg       <= arg_next;
            arg_has_reg   <= arg_has_next;
            align_reg     <= align_next;
            width_reg     <= width_next;
            width_has_reg <= width_has_next;
            prec_reg      <= prec_next;
            prec_has_reg  <= prec_has_next;
            note_reg      <= note_next;
            radix_reg     <= radix_next;
        end
    end

endmodule

@@ rtl/fsp_out_fifo.sv @@
// Result queue: takes up to two result words per cycle, hands out one per cycle while m_ready is high.
// Depends on fsp_pkg.

module fsp_out_fifo (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  fsp_pkg::core_out_t core_out,
    output logic               room,
    output logic               m_valid,
    input  logic               m_ready,
    output fsp_pkg::result_t   head
);

    localparam int PTR_BITS = $clog2(fsp_pkg::RESULT_DEPTH);
    localparam int CNT_BITS = $clog2(fsp_pkg::RESULT_DEPTH + 1);
    localparam logic [CNT_BITS-1:0] ROOM_LIMIT = CNT_BITS'(fsp_pkg::RESULT_DEPTH - 2);

    fsp_pkg::result_t    mem [fsp_pkg::RESULT_DEPTH];
    logic [PTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_BITS-1:0] count_reg, count_next;
    logic                pop;
    logic [CNT_BITS-1:0] push_n;
    logic [CNT_BITS-1:0] after_pop;

    assign m_valid   = (count_reg != '0);
    assign head      = mem[rd_ptr_reg];
    assign pop       = m_valid && m_ready;
    assign after_pop = count_reg - CNT_BITS'(pop);
    // two free words are needed before a character may be parsed
    assign room      = (after_pop <= ROOM_LIMIT);
    assign push_n    = push ? CNT_BITS'(core_out.count) : '0;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + PTR_BITS'(push_n);
        rd_ptr_next = rd_ptr_reg + PTR_BITS'(pop);
        count_next  = after_pop + push_n;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push && core_out.count != 2'd0)
            mem[wr_ptr_reg] <= core_out.res0;
        if (push && core_out.count == 2'd2)
            mem[wr_ptr_reg + PTR_BITS'(1)] <= core_out.res1;
    end

endmodule
